// File: src/srdt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package srdt_pkg;

   // Request function codes
   localparam logic [1:0] FUNC_START    = 2'd0;
   localparam logic [1:0] FUNC_REPORT   = 2'd1;
   localparam logic [1:0] FUNC_COMPLETE = 2'd2;
   localparam logic [1:0] FUNC_READOUT  = 2'd3;

   // Fixed field widths
   localparam int unsigned ADDR_BYTES = 6;
   localparam int unsigned ADDR_W     = 8 * ADDR_BYTES;
   localparam int unsigned LIMIT_W    = 7;
   localparam int unsigned RANK_W     = 6;

   // One request transfer
   typedef struct packed {
      logic [1:0]        func;
      logic [ADDR_W-1:0] adv_address;
      logic [1:0]        adv_address_type;
      logic signed [7:0] adv_rssi;
      logic [LIMIT_W-1:0] limit;
   } srdt_req_type;

   // One table entry, address held in MAC order
   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic [1:0]        atype;
      logic signed [7:0] rssi;
   } srdt_entry_type;

   // One response transfer
   typedef struct packed {
      logic [ADDR_W-1:0] dev_address;
      logic [1:0]        dev_address_type;
      logic signed [7:0] dev_rssi;
      logic [RANK_W-1:0] rank;
      logic              has_entry;
      logic              round_done;
      logic              last;
   } srdt_result_type;

endpackage

`default_nettype wire

// File: src/srdt_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface srdt_req_if;
   logic                              valid;
   logic                              ready;
   logic [1:0]                        func;
   logic [srdt_pkg::ADDR_W-1:0]       adv_address;
   logic [1:0]                        adv_address_type;
   logic signed [7:0]                 adv_rssi;
   logic [srdt_pkg::LIMIT_W-1:0]      limit;

   modport source (output valid, func, adv_address, adv_address_type, adv_rssi, limit,
                   input ready);
   modport sink (input valid, func, adv_address, adv_address_type, adv_rssi, limit,
                 output ready);
endinterface

`default_nettype wire

// File: src/srdt_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface srdt_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [srdt_pkg::ADDR_W-1:0]       dev_address;
   logic [1:0]                        dev_address_type;
   logic signed [7:0]                 dev_rssi;
   logic [srdt_pkg::RANK_W-1:0]       rank;
   logic                              has_entry;
   logic                              round_done;
   logic                              last;

   modport source (output valid, dev_address, dev_address_type, dev_rssi, rank,
                   has_entry, round_done, last, input ready);
   modport sink (input valid, dev_address, dev_address_type, dev_rssi, rank,
                 has_entry, round_done, last, output ready);
endinterface

`default_nettype wire

// File: src/srdt_table_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module srdt_table_ram #(
   parameter int unsigned DEPTH = 64,
   localparam int unsigned IDX_W = $clog2(DEPTH)
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [IDX_W-1:0]         wr_addr,
   input  wire srdt_pkg::srdt_entry_type wr_data,
   input  wire logic [IDX_W-1:0]         rd_addr,
   output srdt_pkg::srdt_entry_type      rd_data
);

   srdt_pkg::srdt_entry_type mem [DEPTH];
   srdt_pkg::srdt_entry_type rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port, old data on a same-address write
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: src/srdt_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module srdt_ctrl #(
   parameter int unsigned TABLE_DEPTH = 64,
   localparam int unsigned IDX_W = $clog2(TABLE_DEPTH),
   localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1)
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   // request side
   input  wire logic                      req_valid,
   input  wire srdt_pkg::srdt_req_type    req_data,
   output logic                           req_ready,
   // result side
   input  wire logic                      slot_free,
   output logic                           res_load,
   output srdt_pkg::srdt_result_type      res_data,
   // table memory
   output logic                           wr_en,
   output logic [IDX_W-1:0]               wr_addr,
   output srdt_pkg::srdt_entry_type       wr_data,
   output logic [IDX_W-1:0]               rd_addr,
   input  wire srdt_pkg::srdt_entry_type  rd_data
);

   localparam int unsigned NUM_W = (CNT_W > srdt_pkg::LIMIT_W) ? CNT_W : srdt_pkg::LIMIT_W;
   localparam int unsigned RANK_W = srdt_pkg::RANK_W;

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_SRCH     = 4'd1;
   localparam logic [3:0] S_KEY      = 4'd2;
   localparam logic [3:0] S_KEYW     = 4'd3;
   localparam logic [3:0] S_CMP      = 4'd4;
   localparam logic [3:0] S_PUT      = 4'd5;
   localparam logic [3:0] S_EMIT_RD  = 4'd6;
   localparam logic [3:0] S_EMIT_OUT = 4'd7;
   localparam logic [3:0] S_EMPTY    = 4'd8;

   function automatic logic [srdt_pkg::ADDR_W-1:0] rev_bytes(
      input logic [srdt_pkg::ADDR_W-1:0] a);
      logic [srdt_pkg::ADDR_W-1:0] r;
      r = '0;
      for (int k = 0; k < srdt_pkg::ADDR_BYTES; k++) begin
         r[8*(srdt_pkg::ADDR_BYTES-1-k) +: 8] = a[8*k +: 8];
      end
      return r;
   endfunction

   logic [3:0]               state_ff, state_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic                     armed_ff, armed_in;
   logic                     done_ff, done_in;
   srdt_pkg::srdt_entry_type key_ff, key_in;
   logic [IDX_W-1:0]         issue_ff, issue_in;
   logic [IDX_W-1:0]         check_ff, check_in;
   logic                     chk_valid_ff, chk_valid_in;
   logic [IDX_W-1:0]         i_ff, i_in;
   logic [IDX_W-1:0]         j_ff, j_in;
   logic [IDX_W-1:0]         k_ff, k_in;
   logic [CNT_W-1:0]         n_ff, n_in;

   srdt_pkg::srdt_entry_type req_entry;
   logic [NUM_W-1:0]         cnt_wide;
   logic [NUM_W-1:0]         lim_wide;
   logic [CNT_W-1:0]         n_req;
   logic                     shift;
   logic                     sort_end;
   logic                     emit_last;
   logic                     search_end;
   logic [RANK_W+IDX_W-1:0]  rank_ext;

   // Decode the incoming report and the readout length
   assign req_entry.addr  = rev_bytes(req_data.adv_address);
   assign req_entry.atype = req_data.adv_address_type;
   assign req_entry.rssi  = req_data.adv_rssi;
   assign cnt_wide  = NUM_W'(count_ff);
   assign lim_wide  = NUM_W'(req_data.limit);
   assign n_req     = (cnt_wide < lim_wide) ? count_ff : CNT_W'(lim_wide);

   // Loop end flags
   assign shift      = (rd_data.rssi < key_ff.rssi);
   assign sort_end   = ((CNT_W'(i_ff) + CNT_W'(1)) == count_ff);
   assign emit_last  = ((CNT_W'(k_ff) + CNT_W'(1)) == n_ff);
   assign search_end = ((CNT_W'(check_ff) + CNT_W'(1)) == count_ff);
   assign rank_ext   = {{RANK_W{1'b0}}, k_ff};

   assign req_ready = (state_ff == S_IDLE);

   // Result payload
   always_comb begin
      res_data = '0;
      res_data.round_done = done_ff;
      res_data.last = 1'b1;
      if (state_ff != S_EMPTY) begin
         res_data.dev_address      = rd_data.addr;
         res_data.dev_address_type = rd_data.atype;
         res_data.dev_rssi         = rd_data.rssi;
         res_data.rank             = rank_ext[RANK_W-1:0];
         res_data.has_entry        = 1'b1;
         res_data.last             = emit_last;
      end
   end

   // Read address select
   always_comb begin
      unique case (state_ff)
         S_SRCH:                rd_addr = issue_ff;
         S_KEY:                 rd_addr = i_ff;
         S_KEYW:                rd_addr = i_ff - IDX_W'(1);
         S_CMP:                 rd_addr = shift ? (j_ff - IDX_W'(2)) : (i_ff + IDX_W'(1));
         S_PUT:                 rd_addr = i_ff + IDX_W'(1);
         S_EMIT_RD, S_EMIT_OUT: rd_addr = k_ff;
         default:               rd_addr = '0;
      endcase
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      armed_in     = armed_ff;
      done_in      = done_ff;
      key_in       = key_ff;
      issue_in     = issue_ff;
      check_in     = check_ff;
      chk_valid_in = chk_valid_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      n_in         = n_ff;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = key_ff;
      res_load     = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               unique case (req_data.func)
                  srdt_pkg::FUNC_START: begin
                     count_in = '0;
                     armed_in = 1'b1;
                  end
                  srdt_pkg::FUNC_REPORT: begin
                     if (armed_ff) begin
                        key_in = req_entry;
                        if (count_ff == '0) begin
                           // empty table: append at once
                           wr_en    = 1'b1;
                           wr_addr  = '0;
                           wr_data  = req_entry;
                           count_in = CNT_W'(1);
                        end else begin
                           issue_in     = '0;
                           chk_valid_in = 1'b0;
                           state_in     = S_SRCH;
                        end
                     end
                  end
                  srdt_pkg::FUNC_COMPLETE: begin
                     armed_in = 1'b0;
                  end
                  srdt_pkg::FUNC_READOUT: begin
                     done_in = !armed_ff;
                     n_in    = n_req;
                     k_in    = '0;
                     if (count_ff >= CNT_W'(2)) begin
                        i_in     = IDX_W'(1);
                        state_in = S_KEY;
                     end else if (n_req == '0) begin
                        state_in = S_EMPTY;
                     end else begin
                        state_in = S_EMIT_RD;
                     end
                  end
                  default: ;
               endcase
            end
         end

         S_SRCH: begin
            // one probe issued and one compared per cycle
            issue_in     = issue_ff + IDX_W'(1);
            check_in     = issue_ff;
            chk_valid_in = 1'b1;
            if (chk_valid_ff) begin
               if (rd_data.addr == key_ff.addr) begin
                  wr_en    = 1'b1;
                  wr_addr  = check_ff;
                  state_in = S_IDLE;
               end else if (search_end) begin
                  if (count_ff < CNT_W'(TABLE_DEPTH)) begin
                     wr_en    = 1'b1;
                     wr_addr  = count_ff[IDX_W-1:0];
                     count_in = count_ff + CNT_W'(1);
                  end
                  state_in = S_IDLE;
               end
            end
         end

         S_KEY: begin
            state_in = S_KEYW;
         end

         S_KEYW: begin
            key_in   = rd_data;
            j_in     = i_ff;
            state_in = S_CMP;
         end

         S_CMP: begin
            wr_en   = 1'b1;
            wr_addr = j_ff;
            if (shift) begin
               // move the weaker entry up one slot
               wr_data = rd_data;
               j_in    = j_ff - IDX_W'(1);
               if (j_ff == IDX_W'(1)) begin
                  state_in = S_PUT;
               end
            end else begin
               wr_data = key_ff;
               if (sort_end) begin
                  state_in = (n_ff == '0) ? S_EMPTY : S_EMIT_RD;
               end else begin
                  i_in     = i_ff + IDX_W'(1);
                  state_in = S_KEYW;
               end
            end
         end

         S_PUT: begin
            wr_en   = 1'b1;
            wr_addr = j_ff;
            wr_data = key_ff;
            if (sort_end) begin
               state_in = (n_ff == '0) ? S_EMPTY : S_EMIT_RD;
            end else begin
               i_in     = i_ff + IDX_W'(1);
               state_in = S_KEYW;
            end
         end

         S_EMIT_RD: begin
            state_in = S_EMIT_OUT;
         end

         S_EMIT_OUT: begin
            if (slot_free) begin
               res_load = 1'b1;
               if (emit_last) begin
                  state_in = S_IDLE;
               end else begin
                  k_in     = k_ff + IDX_W'(1);
                  state_in = S_EMIT_RD;
               end
            end
         end

         S_EMPTY: begin
            if (slot_free) begin
               res_load = 1'b1;
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         armed_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         armed_ff <= armed_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      done_ff      <= done_in;
      key_ff       <= key_in;
      issue_ff     <= issue_in;
      check_ff     <= check_in;
      chk_valid_ff <= chk_valid_in;
      i_ff         <= i_in;
      j_ff         <= j_in;
      k_ff         <= k_in;
      n_ff         <= n_in;
   end

endmodule

`default_nettype wire

// File: src/scan_result_dedup_table_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Duplicate filter for the advertisement reports of one scan round.
// req_chan takes one command per transfer: start (clear table, arm), report
// (look up the byte-reversed address, update or append), complete (disarm)
// and readout. Only a readout produces transfers on rsp_chan: up to 'limit'
// entries in descending RSSI order, the final one flagged last, or a single
// has_entry=0 transfer when nothing is to be delivered.
// Operation:
//   start, complete, report while disarmed or on an empty table: done in the idle state.
//   report: searches the table, one entry compared per cycle.
//   readout: the table is insertion-sorted in place first, loading the first
//   key, then comparing each entry and moving each displaced entry up a slot,
//   then the results are emitted one by one. All steps share the single
//   read port of the table.
// req_chan.ready is high only while no command is in progress.
// A result waits in the output register while rsp_chan.ready is low; the
// next command can be taken meanwhile, and a readout stalls until the
// register frees up.
// Reset clears the entry count, disarms scanning and empties the output
// register; the table contents need no clearing.
module scan_result_dedup_table_core #(
   parameter int unsigned TABLE_DEPTH = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   srdt_req_if.sink         req_chan,
   srdt_rsp_if.source       rsp_chan
);

   localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);

   srdt_pkg::srdt_req_type    req_data;
   srdt_pkg::srdt_result_type res_data;
   srdt_pkg::srdt_result_type rsp_data_ff;
   srdt_pkg::srdt_entry_type  wr_data;
   srdt_pkg::srdt_entry_type  rd_data;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      req_ready;
   logic                      slot_free;
   logic                      res_load;
   logic                      wr_en;
   logic [IDX_W-1:0]          wr_addr;
   logic [IDX_W-1:0]          rd_addr;

   // Gather request payload
   assign req_data.func             = req_chan.func;
   assign req_data.adv_address      = req_chan.adv_address;
   assign req_data.adv_address_type = req_chan.adv_address_type;
   assign req_data.adv_rssi         = req_chan.adv_rssi;
   assign req_data.limit            = req_chan.limit;
   assign req_chan.ready            = req_ready;

   srdt_ctrl #(.TABLE_DEPTH(TABLE_DEPTH)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_data  (req_data),
      .req_ready (req_ready),
      .slot_free (slot_free),
      .res_load  (res_load),
      .res_data  (res_data),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data)
   );

   srdt_table_ram #(.DEPTH(TABLE_DEPTH)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Output register: hold until transfer, reload when free
   assign slot_free    = !rsp_valid_ff || rsp_chan.ready;
   assign rsp_valid_in = res_load || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_load) begin
         rsp_data_ff <= res_data;
      end
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.dev_address      = rsp_data_ff.dev_address;
   assign rsp_chan.dev_address_type = rsp_data_ff.dev_address_type;
   assign rsp_chan.dev_rssi         = rsp_data_ff.dev_rssi;
   assign rsp_chan.rank             = rsp_data_ff.rank;
   assign rsp_chan.has_entry        = rsp_data_ff.has_entry;
   assign rsp_chan.round_done       = rsp_data_ff.round_done;
   assign rsp_chan.last             = rsp_data_ff.last;

   // Results are produced only while a readout is in progress
   assert property (@(posedge clock) disable iff (reset) res_load |-> !req_ready)
      else $error("result loaded while idle");

   // Never overwrite a result that has not been transferred
   assert property (@(posedge clock) disable iff (reset)
                    res_load |-> (!rsp_valid_ff || rsp_chan.ready))
      else $error("pending result overwritten");

   // A readout always keeps the block busy on the next cycle
   assert property (@(posedge clock) disable iff (reset)
                    (req_chan.valid && req_ready && req_chan.func == srdt_pkg::FUNC_READOUT)
                    |=> !req_ready)
      else $error("readout did not start");

   // An empty readout is a single, final transfer
   assert property (@(posedge clock) disable iff (reset)
                    (rsp_valid_ff && !rsp_data_ff.has_entry) |-> rsp_data_ff.last)
      else $error("empty result not marked last");

endmodule

`default_nettype wire

// File: tb/sv/tb_scan_result_dedup_table_core.sv
`timescale 1ns / 1ps

module tb_scan_result_dedup_table_core;

   localparam int HEARD_DEPTH   = 64;
   localparam int STALL_LIMIT   = 20000;
   localparam int SETTLE_CYCLES = 3000;

   logic clock;
   logic reset;

   srdt_req_if req_bus ();
   srdt_rsp_if rsp_bus ();

   scan_result_dedup_table_core #(
      .TABLE_DEPTH(HEARD_DEPTH)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // Commands waiting to be sent and readout entries waiting to come back
   srdt_pkg::srdt_req_type    pending_reqs[$];
   srdt_pkg::srdt_result_type expected_readout[$];
   srdt_pkg::srdt_result_type readout_head;

   // Mirror of the advertiser table
   srdt_pkg::srdt_entry_type heard[HEARD_DEPTH];
   int                       heard_count;
   bit                       heard_armed;

   bit gen_armed;
   int stim_count;
   int accepted_count;
   int mismatch_count;
   int quiet_cycles;
   bit req_fire;
   bit steady;

   // No idling on either side for a stretch in the middle of the run
   assign steady = (accepted_count >= 110) && (accepted_count < 170);

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   function automatic void report_failure(string what);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("mismatch: %s", what);
      end
   endfunction

   function automatic void compare_field(string field, logic [47:0] want, logic [47:0] got);
      if (want !== got) begin
         report_failure($sformatf("%s expected %0h, got %0h", field, want, got));
      end
   endfunction

   // Turn on-air byte order into MAC order
   function automatic logic [47:0] to_mac_order(logic [47:0] air);
      logic [47:0] mac;
      for (int k = 0; k < 6; k++) begin
         mac[8*(5-k) +: 8] = air[8*k +: 8];
      end
      return mac;
   endfunction

   // Stable insertion sort, strongest first; the table stays sorted afterward
   function automatic void rank_by_strength();
      srdt_pkg::srdt_entry_type held;
      int j;
      for (int i = 1; i < heard_count; i++) begin
         held = heard[i];
         j = i;
         while (j > 0 && $signed(heard[j-1].rssi) < $signed(held.rssi)) begin
            heard[j] = heard[j-1];
            j--;
         end
         heard[j] = held;
      end
   endfunction

   // Advance the table mirror by one command and queue the readout entries
   function automatic void track_command(srdt_pkg::srdt_req_type cmd);
      logic [47:0]               mac;
      int                        slot;
      int                        n;
      srdt_pkg::srdt_result_type r;
      case (cmd.func)
         srdt_pkg::FUNC_START: begin
            heard_count = 0;
            heard_armed = 1'b1;
         end
         srdt_pkg::FUNC_REPORT: begin
            if (heard_armed) begin
               mac = to_mac_order(cmd.adv_address);
               slot = heard_count;
               for (int i = 0; i < heard_count; i++) begin
                  if (heard[i].addr == mac && slot == heard_count) begin
                     slot = i;
                  end
               end
               // Drop a new advertiser once the table is full
               if (slot == heard_count && heard_count < HEARD_DEPTH) begin
                  heard[slot].addr = mac;
                  heard_count++;
               end
               if (slot < heard_count) begin
                  heard[slot].atype = cmd.adv_address_type;
                  heard[slot].rssi  = cmd.adv_rssi;
               end
            end
         end
         srdt_pkg::FUNC_COMPLETE: begin
            heard_armed = 1'b0;
         end
         srdt_pkg::FUNC_READOUT: begin
            rank_by_strength();
            n = (heard_count < int'(cmd.limit)) ? heard_count : int'(cmd.limit);
            if (n == 0) begin
               r = '0;
               r.round_done = !heard_armed;
               r.last = 1'b1;
               expected_readout.push_back(r);
            end
            for (int k = 0; k < n; k++) begin
               r.dev_address      = heard[k].addr;
               r.dev_address_type = heard[k].atype;
               r.dev_rssi         = heard[k].rssi;
               r.rank             = k[5:0];
               r.has_entry        = 1'b1;
               r.round_done       = !heard_armed;
               r.last             = (k + 1 == n);
               expected_readout.push_back(r);
            end
         end
         default: ;
      endcase
   endfunction

   function automatic logic [47:0] rand_addr();
      return 48'({$urandom, $urandom});
   endfunction

   function automatic logic [7:0] rand_rssi();
      // Favor a few close values so that ties show up
      if ($urandom_range(2) == 0) begin
         return 8'(-40 - 5 * $urandom_range(3));
      end
      return 8'($urandom);
   endfunction

   function automatic void push_cmd(logic [1:0] func, logic [47:0] addr, logic [1:0] atype,
                                    logic [7:0] rssi, logic [6:0] lim);
      srdt_pkg::srdt_req_type c;
      c.func             = func;
      c.adv_address      = addr;
      c.adv_address_type = atype;
      c.adv_rssi         = rssi;
      c.limit            = lim;
      pending_reqs.push_back(c);
      // Reports while disarmed are ignored by the block and do not count
      if (!(func == srdt_pkg::FUNC_REPORT && !gen_armed)) begin
         stim_count++;
      end
      if (func == srdt_pkg::FUNC_START) begin
         gen_armed = 1'b1;
      end else if (func == srdt_pkg::FUNC_COMPLETE) begin
         gen_armed = 1'b0;
      end
   endfunction

   function automatic void push_readout(logic [6:0] lim);
      push_cmd(srdt_pkg::FUNC_READOUT, rand_addr(), 2'($urandom), 8'($urandom), lim);
   endfunction

   // One scan round with repeated advertisers, mid-round readouts and noise
   function automatic void add_round(int reports, int reuse_pct);
      logic [47:0] pool[$];
      logic [47:0] addr;
      push_cmd(srdt_pkg::FUNC_START, rand_addr(), 2'($urandom), 8'($urandom),
               7'($urandom));
      for (int i = 0; i < reports; i++) begin
         if (pool.size() != 0 && $urandom_range(99) < reuse_pct) begin
            addr = pool[$urandom_range(pool.size() - 1)];
         end else begin
            addr = rand_addr();
            pool.push_back(addr);
         end
         push_cmd(srdt_pkg::FUNC_REPORT, addr, 2'($urandom), rand_rssi(), 7'($urandom));
         if ($urandom_range(99) < 6) begin
            push_readout(7'($urandom_range(64)));
         end else if ($urandom_range(99) < 3) begin
            push_cmd(2'($urandom), rand_addr(), 2'($urandom), 8'($urandom),
                     7'($urandom_range(64)));
         end
      end
      if ($urandom_range(9) != 0) begin
         push_cmd(srdt_pkg::FUNC_COMPLETE, rand_addr(), 2'($urandom), 8'($urandom),
                  7'($urandom));
      end
      repeat ($urandom_range(2)) begin
         push_cmd(srdt_pkg::FUNC_REPORT, rand_addr(), 2'($urandom), rand_rssi(),
                  7'($urandom));
      end
      repeat ($urandom_range(1, 2)) begin
         push_readout(($urandom_range(3) == 0) ? 7'($urandom_range(64)) : 7'd64);
      end
   endfunction

   // Request driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         req_fire = req_bus.valid && req_bus.ready;
         if (req_fire) begin
            track_command(pending_reqs.pop_front());
            accepted_count <= accepted_count + 1;
         end
         if (req_bus.valid && !req_fire) begin
            // hold the item until the block takes it
         end else if (pending_reqs.size() != 0 && (steady || $urandom_range(99) >= 32)) begin
            req_bus.valid            <= 1'b1;
            req_bus.func             <= pending_reqs[0].func;
            req_bus.adv_address      <= pending_reqs[0].adv_address;
            req_bus.adv_address_type <= pending_reqs[0].adv_address_type;
            req_bus.adv_rssi         <= pending_reqs[0].adv_rssi;
            req_bus.limit            <= pending_reqs[0].limit;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Result monitor and random backpressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_readout.size() == 0) begin
               report_failure($sformatf("result with nothing expected, address %0h",
                                        rsp_bus.dev_address));
            end else begin
               readout_head = expected_readout.pop_front();
               compare_field("dev_address", readout_head.dev_address, rsp_bus.dev_address);
               compare_field("dev_address_type", 48'(readout_head.dev_address_type),
                             48'(rsp_bus.dev_address_type));
               compare_field("dev_rssi", 48'(readout_head.dev_rssi), 48'(rsp_bus.dev_rssi));
               compare_field("rank", 48'(readout_head.rank), 48'(rsp_bus.rank));
               compare_field("has_entry", 48'(readout_head.has_entry),
                             48'(rsp_bus.has_entry));
               compare_field("round_done", 48'(readout_head.round_done),
                             48'(rsp_bus.round_done));
               compare_field("last", 48'(readout_head.last), 48'(rsp_bus.last));
            end
         end
         rsp_bus.ready <= steady || ($urandom_range(99) >= 32);
      end
   end

   // Watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.func = srdt_pkg::FUNC_START;
      req_bus.adv_address = '0;
      req_bus.adv_address_type = '0;
      req_bus.adv_rssi = '0;
      req_bus.limit = '0;
      rsp_bus.ready = 1'b0;
      heard_count = 0;
      heard_armed = 1'b0;
      gen_armed = 1'b0;
      stim_count = 0;
      accepted_count = 0;
      mismatch_count = 0;
      quiet_cycles = 0;

      // Directed: empty readouts, ignored reports, address and RSSI extremes,
      // ties, updates after a sort, readout while armed, clearing by start
      push_readout(7'd5);
      push_cmd(srdt_pkg::FUNC_REPORT, 48'h060504030201, 2'd1, 8'sd10, 7'd0);
      push_cmd(srdt_pkg::FUNC_START, 48'h0, 2'd0, 8'sd0, 7'd0);
      push_readout(7'd0);
      push_cmd(srdt_pkg::FUNC_REPORT, 48'h000000000000, 2'd0, -8'sd128, 7'd0);
      push_cmd(srdt_pkg::FUNC_REPORT, 48'hFFFFFFFFFFFF, 2'd3, 8'sd127, 7'h7F);
      push_cmd(srdt_pkg::FUNC_REPORT, 48'h060504030201, 2'd1, -8'sd60, 7'd0);
      push_cmd(srdt_pkg::FUNC_REPORT, 48'hA1B2C3D4E5F6, 2'd2, -8'sd60, 7'd0);
      push_cmd(srdt_pkg::FUNC_REPORT, 48'h060504030201, 2'd2, -8'sd60, 7'd0);
      push_readout(7'd64);
      push_cmd(srdt_pkg::FUNC_REPORT, 48'h000000000000, 2'd3, 8'sd0, 7'd0);
      push_readout(7'd2);
      push_readout(7'd1);
      push_cmd(srdt_pkg::FUNC_COMPLETE, 48'h0, 2'd0, 8'sd0, 7'd0);
      push_cmd(srdt_pkg::FUNC_REPORT, 48'h123456789ABC, 2'd1, 8'sd5, 7'd0);
      push_readout(7'd64);
      push_readout(7'd0);
      push_cmd(srdt_pkg::FUNC_START, 48'h0, 2'd0, 8'sd0, 7'd0);
      push_readout(7'd64);
      push_cmd(srdt_pkg::FUNC_COMPLETE, 48'h0, 2'd0, 8'sd0, 7'd0);
      push_cmd(srdt_pkg::FUNC_COMPLETE, 48'h0, 2'd0, 8'sd0, 7'd0);

      // Random: one round that overflows the table, then ordinary rounds
      add_round(80, 8);
      while (stim_count < 205) begin
         add_round($urandom_range(3, 20), 25);
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Drain, then give any stray result time to show up
      while (pending_reqs.size() != 0) @(posedge clock);
      while (expected_readout.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (expected_readout.size() != 0) begin
         report_failure("readout entries still outstanding at the end");
      end
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
